// ===== rtl/cfr_pkg.sv =====
// Package for the complex FIR decimator: payload structs, command queue entry,
// mode codes and command kinds. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cfr_pkg;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_TAP    = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_TAP    = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam int FACTOR_MAX = 64;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] in_real;
        logic signed [15:0] in_imag;
        logic [5:0]         tap_index;
        logic signed [15:0] tap_real;
        logic signed [15:0] tap_imag;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_real;
        logic signed [15:0] out_imag;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic [1:0]         kind;
        logic               emit;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic [5:0]         idx;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== rtl/cfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/cfr_front.sv =====
// Front end: accepts input beats, tracks decimation phase, turns beats into commands.
// Depends on cfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfr_front
    import cfr_pkg::*;
#(
    parameter int NUM_TAPS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in        i_in,
    input  wire t_q_stat    i_q_stat,
    output logic            o_push,
    output t_cmd            o_cmd
);
    logic [6:0] r_factor, n_factor;
    logic [5:0] r_phase, n_phase;
    logic [6:0] eff;
    logic [6:0] nph;
    logic       fire;

    assign o_ready = !i_q_stat.full;
    assign fire    = i_valid && o_ready;

    always_comb begin
        if (r_factor == 7'd0) begin
            eff = 7'd1;
        end else if (r_factor > 7'(FACTOR_MAX)) begin
            eff = 7'(FACTOR_MAX);
        end else begin
            eff = r_factor;
        end
        nph     = {1'b0, r_phase} + 7'd1;
        n_phase = r_phase;
        n_factor = i_cfg_we ? i_cfg_wdata : r_factor;
        o_push  = 1'b0;
        o_cmd.kind = CMD_SAMPLE;
        o_cmd.emit = 1'b0;
        o_cmd.a    = i_in.in_real;
        o_cmd.b    = i_in.in_imag;
        o_cmd.idx  = i_in.tap_index;
        if (fire) begin
            unique case (i_in.mode)
                MODE_SAMPLE: begin
                    o_push     = 1'b1;
                    o_cmd.emit = (nph >= eff);
                    n_phase    = (nph >= eff) ? 6'd0 : nph[5:0];
                end
                MODE_TAP: begin
                    o_push     = (32'(i_in.tap_index) < NUM_TAPS);
                    o_cmd.kind = CMD_TAP;
                    o_cmd.a    = i_in.tap_real;
                    o_cmd.b    = i_in.tap_imag;
                end
                MODE_CLEAR: begin
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_CLEAR;
                    n_phase    = 6'd0;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= 7'd1;
            r_phase  <= 6'd0;
        end else begin
            r_factor <= n_factor;
            r_phase  <= n_phase;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cfr_queue.sv =====
// Two-entry command queue between front end and datapath.
// Depends on cfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfr_queue
    import cfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output t_q_stat   o_stat
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cfr_back.sv =====
// Datapath: history and tap memories, one-tap-per-cycle complex MAC, rounding,
// saturation and output register. Depends on cfr_pkg and cfr_ram.
`timescale 1ns / 1ps
`default_nettype none
module cfr_back
    import cfr_pkg::*;
#(
    parameter int NUM_TAPS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_pop,
    output logic      o_busy,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_out
);
    localparam int ADDR_W = $clog2(NUM_TAPS);
    localparam int FILL_W = $clog2(NUM_TAPS + 1);
    localparam int ACC_W  = 33 + $clog2(NUM_TAPS);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    function automatic logic [16:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] v;
        logic signed [ACC_W:0] q;
        v = (ACC_W + 1)'(acc) + (ACC_W + 1)'(16384);
        q = v >>> 15;
        if (q > (ACC_W + 1)'(32767)) begin
            round_sat = {1'b1, 16'h7fff};
        end else if (q < -(ACC_W + 1)'(32768)) begin
            round_sat = {1'b1, 16'h8000};
        end else begin
            round_sat = {1'b0, q[15:0]};
        end
    endfunction

    logic [1:0]              r_state;
    logic [ADDR_W-1:0]       r_wptr, r_rd_ptr, r_k;
    logic [FILL_W-1:0]       r_fill;
    logic                    r_v1, r_m1, r_pv;
    logic signed [31:0]      r_prr, r_pii, r_pri, r_pir;
    logic signed [ACC_W-1:0] r_acc_r, r_acc_i;
    logic                    r_out_valid;
    t_out                    r_out;

    logic                    hist_we, coef_we;
    logic [ADDR_W-1:0]       coef_waddr;
    logic [ADDR_W+5:0]       idx_wide;
    logic [31:0]             hist_rdata, coef_rdata;
    logic signed [15:0]      xr, xi, hr, hi;
    logic                    load;
    logic [16:0]             rs_r, rs_i;

    assign o_pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_busy     = (r_state != S_IDLE);
    assign hist_we    = o_pop && (i_cmd.kind == CMD_SAMPLE);
    assign coef_we    = o_pop && (i_cmd.kind == CMD_TAP);
    assign idx_wide   = (ADDR_W + 6)'(i_cmd.idx);
    assign coef_waddr = idx_wide[ADDR_W-1:0];

    cfr_ram #(.WIDTH(32), .DEPTH(NUM_TAPS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_wptr),
        .i_wdata ({i_cmd.a, i_cmd.b}),
        .i_raddr (r_rd_ptr),
        .o_rdata (hist_rdata)
    );

    cfr_ram #(.WIDTH(32), .DEPTH(NUM_TAPS)) u_coef (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata ({i_cmd.a, i_cmd.b}),
        .i_raddr (r_k),
        .o_rdata (coef_rdata)
    );

    assign xr = r_m1 ? hist_rdata[31:16] : 16'sd0;
    assign xi = r_m1 ? hist_rdata[15:0]  : 16'sd0;
    assign hr = coef_rdata[31:16];
    assign hi = coef_rdata[15:0];

    assign rs_r = round_sat(r_acc_r);
    assign rs_i = round_sat(r_acc_i);
    assign load = (r_state == S_FIN) && !r_v1 && !r_pv && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        r_prr <= xr * hr;
        r_pii <= xi * hi;
        r_pri <= xr * hi;
        r_pir <= xi * hr;
        r_m1  <= (FILL_W'(r_k) < r_fill);
        if (o_pop && (i_cmd.kind == CMD_SAMPLE) && i_cmd.emit) begin
            r_acc_r <= '0;
            r_acc_i <= '0;
        end else if (r_pv) begin
            r_acc_r <= r_acc_r + ACC_W'(r_prr) - ACC_W'(r_pii);
            r_acc_i <= r_acc_i + ACC_W'(r_pri) + ACC_W'(r_pir);
        end
        if (load) begin
            r_out.out_real  <= rs_r[15:0];
            r_out.out_imag  <= rs_i[15:0];
            r_out.saturated <= rs_r[16] | rs_i[16];
        end
        if (o_pop && (i_cmd.kind == CMD_SAMPLE)) begin
            r_rd_ptr <= r_wptr;
        end else if (r_state == S_RUN) begin
            r_rd_ptr <= (r_rd_ptr == '0) ? ADDR_W'(NUM_TAPS - 1) : r_rd_ptr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wptr      <= '0;
            r_k         <= '0;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_RUN);
            r_pv <= r_v1;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.kind)
                            CMD_SAMPLE: begin
                                r_wptr <= (r_wptr == ADDR_W'(NUM_TAPS - 1)) ? '0
                                                                          : r_wptr + 1'b1;
                                if (r_fill != FILL_W'(NUM_TAPS)) begin
                                    r_fill <= r_fill + 1'b1;
                                end
                                if (i_cmd.emit) begin
                                    r_k     <= '0;
                                    r_state <= S_RUN;
                                end
                            end
                            CMD_CLEAR: begin
                                r_fill <= '0;
                            end
                            default: begin
                                r_fill <= r_fill;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == ADDR_W'(NUM_TAPS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;
endmodule
`default_nettype wire

// ===== rtl/complex_fir_decimator.sv =====
// Top level of the complex FIR decimator: front end, command queue, MAC datapath.
// Depends on cfr_pkg, cfr_front, cfr_queue, cfr_back (and cfr_ram below it).
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    t_in  i_in
//  out       output     o_out_valid / i_out_ready  t_out o_out
//  cfg       input      i_cfg_we                   i_cfg_wdata[6:0]
//
// Tap writes, clears and non-emitting samples are taken while the datapath is idle.
// An emitting sample runs one complex tap per cycle through the single MAC, read from
// the history and tap RAM ports.
// Synchronous active-low reset; history reads as zero after reset or clear.
// The queue holds two beats, so input is still accepted while the MAC or output stalls, until the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module complex_fir_decimator
    import cfr_pkg::*;
#(
    parameter int NUM_TAPS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in        i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out            o_out
);
    logic    push, pop, busy;
    t_cmd    push_cmd, q_cmd;
    t_q_stat q_stat;

    cfr_front #(.NUM_TAPS(NUM_TAPS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_in        (i_in),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    cfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    cfr_back #(.NUM_TAPS(NUM_TAPS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_stat.empty),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_out       (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty))
        else $error("pop from empty queue");

    a_out_from_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(busy))
        else $error("output beat without MAC run");
endmodule
`default_nettype wire
